[sv/assert_macros.svh]
// Assertion macros shared by the heap queue RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define HPQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence on the next edge.
`define HPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    `HPQ_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

[sv/hpq_pkg.sv]
// Package for the min-heap priority queue: beat types, codes, depth helpers.
// No dependencies; the core and the sequencer import it.
`timescale 1ns / 1ps

package hpq_pkg;

    localparam int HPQ_DEPTH_DEFAULT = 64;
    localparam int CNT_W             = 7;
    localparam int KEY_W             = 16;
    localparam int VAL_W             = 32;
    localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

    // Operation codes
    localparam logic [1:0] KIND_INSERT   = 2'd0;
    localparam logic [1:0] KIND_DECREASE = 2'd1;
    localparam logic [1:0] KIND_EXTRACT  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [1:0]              kind;
        logic [KEY_W-1:0]        item_key;
        logic signed [VAL_W-1:0] item_value;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]              status;
        logic [KEY_W-1:0]        out_key;
        logic signed [VAL_W-1:0] out_value;
        logic [CNT_W-1:0]        entry_count;
    } t_out_beat;

    typedef struct packed {
        logic [CNT_W-1:0] capacity;
    } t_cfg_beat;

    typedef struct packed {
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] value;
    } t_entry;

    // Result handoff from the sequencer to the output register
    typedef struct packed {
        logic      valid;
        t_out_beat beat;
    } t_res_xfer;

    // Largest count the built memory allows, limited to the count width.
    function automatic logic [CNT_W-1:0] hpq_depth_cap(input int depth);
        logic [CNT_W-1:0] cap;
        cap = (depth > 127) ? 7'd127 : CNT_W'(depth);
        return cap;
    endfunction

endpackage

[sv/hpq_chan_if.sv]
// Valid/ready channel carrying one payload beat.
// Payload type comes from hpq_pkg at the instance.
`timescale 1ns / 1ps

interface hpq_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[sv/min_heap_priority_queue_core.sv]
// Top level of the min-heap priority queue: capacity register and result register.
// Depends on hpq_pkg, hpq_chan_if, hpq_ctrl and assert_macros.svh.
//
//   channel  | dir | payload                                   | beat taken when
//   ---------+-----+-------------------------------------------+-----------------
//   i_cmd    | in  | kind, item_key, item_value                | valid && ready
//   o_res    | out | status, out_key, out_value, entry_count   | valid && ready
//   i_cfg    | in  | capacity                                  | valid && ready
//
// One command at a time; i_cmd.ready is high only while the sequencer is idle.
// Each command steps through the heap RAM, one RAM access per cycle: insert climbs
//   the levels it moves, extract sifts down them, and decrease scans the held entries
//   for the key before it climbs; the scan and the RAM accesses set the pace.
// Reset clears count and control; RAM contents stay undefined until written.
// A stalled result holds in o_res while the next command is already running.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module min_heap_priority_queue_core import hpq_pkg::*; #(
    parameter int HEAP_DEPTH = HPQ_DEPTH_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hpq_chan_if.sink   i_cmd,
    hpq_chan_if.source o_res,
    hpq_chan_if.sink   i_cfg
);

    localparam logic [CNT_W-1:0] DEPTH_CAP = hpq_depth_cap(HEAP_DEPTH);

    logic [CNT_W-1:0] r_capacity;
    logic [CNT_W-1:0] w_limit;
    logic             r_out_vld, n_out_vld;
    t_out_beat        r_out, n_out;
    t_res_xfer        w_res;
    logic             w_res_ready;

    // Capacity writes are accepted every cycle.
    assign i_cfg.ready = 1'b1;

    // Effective limit: the smaller of capacity and the built depth.
    assign w_limit = (r_capacity < DEPTH_CAP) ? r_capacity : DEPTH_CAP;

    // Take a new result when the output register is empty or draining.
    assign w_res_ready = !r_out_vld || o_res.ready;

    hpq_ctrl #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .i_limit     (w_limit),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    always_comb begin
        n_out_vld = r_out_vld;
        n_out     = r_out;
        if (w_res.valid && w_res_ready) begin
            // Load the finished result over the beat being drained.
            n_out_vld = 1'b1;
            n_out     = w_res.beat;
        end else if (o_res.ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_capacity <= i_cfg.payload.capacity;
            end
            r_out_vld <= n_out_vld;
        end
        r_out <= n_out;
    end

    assign o_res.valid   = r_out_vld;
    assign o_res.payload = r_out;

    `HPQ_ASSERT_NEXT(a_cap_hold, !i_cfg.valid, $stable(r_capacity), "capacity changed without a write beat")
    `HPQ_ASSERT_NEXT(a_res_load, w_res.valid && w_res_ready, r_out_vld, "finished result not loaded")
    `HPQ_ASSERT_NEXT(a_res_drain, r_out_vld && o_res.ready && !w_res.valid, !r_out_vld, "drained result still shown")

endmodule

[sv/hpq_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module hpq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/hpq_ctrl.sv]
// Heap sequencer: insert, decrease-key scan and sift up/down over the heap RAM.
// Depends on hpq_pkg, hpq_chan_if, hpq_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hpq_ctrl import hpq_pkg::*; #(
    parameter int HEAP_DEPTH = HPQ_DEPTH_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    hpq_chan_if.sink         i_cmd,
    input  logic [CNT_W-1:0] i_limit,
    input  logic             i_res_ready,
    output t_res_xfer        o_res
);

    localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int EW = $bits(t_entry);
    localparam logic [CNT_W-1:0] DEPTH_CAP = hpq_depth_cap(HEAP_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_SCAN,
        S_EX_ROOT,
        S_EX_LAST,
        S_DN_L,
        S_DN_R,
        S_DN_CMP,
        S_DONE
    } t_state;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [CNT_W-1:0]        r_idx, n_idx;
    t_entry                  r_cur, n_cur;
    t_entry                  r_lft, n_lft;
    logic                    r_rvld, n_rvld;
    logic [CNT_W-1:0]        r_scan, n_scan;
    logic                    r_chk_vld, n_chk_vld;
    logic [CNT_W-1:0]        r_chk_idx, n_chk_idx;
    logic [1:0]              r_status, n_status;
    logic [KEY_W-1:0]        r_okey, n_okey;
    logic signed [VAL_W-1:0] r_oval, n_oval;

    logic                 w_we;
    logic [CNT_W-1:0]     w_widx;
    t_entry               w_wdata;
    logic [CNT_W-1:0]     w_ridx;
    logic [EW-1:0]        w_rdata_raw;
    t_entry               w_rd;
    logic [CNT_W-1:0]     w_par;
    logic [CNT_W:0]       w_lft_i;
    logic [CNT_W:0]       w_rgt_i;
    logic [CNT_W:0]       w_cnt_x;
    logic                 w_left_lt;
    logic                 w_r_lt_l;
    logic                 w_r_lt_c;
    logic                 w_pick_r;

    hpq_ram #(
        .WIDTH (EW),
        .DEPTH (HEAP_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(w_widx)),
        .i_wdata (w_wdata),
        .i_raddr (AW'(w_ridx)),
        .o_rdata (w_rdata_raw)
    );

    assign w_rd    = t_entry'(w_rdata_raw);
    assign w_par   = (r_idx - 7'd1) >> 1;
    assign w_lft_i = {r_idx, 1'b1};
    assign w_rgt_i = {r_idx, 1'b0} + 8'd2;
    assign w_cnt_x = {1'b0, r_count};

    // Child compares run side by side; the right child needs only one of them.
    assign w_left_lt = $signed(r_lft.value) < $signed(r_cur.value);
    assign w_r_lt_l  = $signed(w_rd.value) < $signed(r_lft.value);
    assign w_r_lt_c  = $signed(w_rd.value) < $signed(r_cur.value);
    assign w_pick_r  = r_rvld && (w_left_lt ? w_r_lt_l : w_r_lt_c);

    assign i_cmd.ready       = (r_state == S_IDLE);
    assign o_res             = '{valid: (r_state == S_DONE),
                                 beat: '{status: r_status, out_key: r_okey,
                                         out_value: r_oval, entry_count: r_count}};

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_cur     = r_cur;
        n_lft     = r_lft;
        n_rvld    = r_rvld;
        n_scan    = r_scan;
        n_chk_vld = r_chk_vld;
        n_chk_idx = r_chk_idx;
        n_status  = r_status;
        n_okey    = r_okey;
        n_oval    = r_oval;
        w_we      = 1'b0;
        w_widx    = r_idx;
        w_wdata   = r_cur;
        w_ridx    = '0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_status = ST_OK;
                    n_okey   = '0;
                    n_oval   = '0;
                    n_cur    = '{key: i_cmd.payload.item_key,
                                 value: i_cmd.payload.item_value};
                    case (i_cmd.payload.kind)
                        KIND_INSERT: begin
                            if (r_count >= i_limit) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else begin
                                n_idx   = r_count;
                                n_count = r_count + 7'd1;
                                n_state = S_UP_RD;
                            end
                        end
                        KIND_DECREASE: begin
                            n_scan    = '0;
                            n_chk_vld = 1'b0;
                            n_state   = S_SCAN;
                        end
                        KIND_EXTRACT: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                w_ridx  = '0;
                                n_state = S_EX_ROOT;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_UP_RD: begin
                if (r_idx == '0) begin
                    w_we    = 1'b1;
                    n_state = S_DONE;
                end else begin
                    w_ridx  = w_par;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                w_we = 1'b1;
                if ($signed(w_rd.value) > $signed(r_cur.value)) begin
                    // Pull the parent down into the hole and climb.
                    w_wdata = w_rd;
                    n_idx   = w_par;
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (r_chk_vld && (w_rd.key == r_cur.key)) begin
                    n_idx   = r_chk_idx;
                    n_state = S_UP_RD;
                end else if (r_scan < r_count) begin
                    w_ridx    = r_scan;
                    n_chk_idx = r_scan;
                    n_chk_vld = 1'b1;
                    n_scan    = r_scan + 7'd1;
                end else begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_DONE;
                end
            end
            S_EX_ROOT: begin
                n_okey  = w_rd.key;
                n_oval  = w_rd.value;
                w_ridx  = r_count - 7'd1;
                n_state = S_EX_LAST;
            end
            S_EX_LAST: begin
                n_cur   = w_rd;
                n_count = r_count - 7'd1;
                n_idx   = '0;
                n_state = (r_count == 7'd1) ? S_DONE : S_DN_L;
            end
            S_DN_L: begin
                if (w_lft_i >= w_cnt_x) begin
                    w_we    = 1'b1;
                    n_state = S_DONE;
                end else begin
                    w_ridx  = w_lft_i[CNT_W-1:0];
                    n_state = S_DN_R;
                end
            end
            S_DN_R: begin
                n_lft   = w_rd;
                n_rvld  = w_rgt_i < w_cnt_x;
                w_ridx  = w_rgt_i[CNT_W-1:0];
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                w_we = 1'b1;
                if (w_pick_r) begin
                    w_wdata = w_rd;
                    n_idx   = w_rgt_i[CNT_W-1:0];
                    n_state = S_DN_L;
                end else if (w_left_lt) begin
                    w_wdata = r_lft;
                    n_idx   = w_lft_i[CNT_W-1:0];
                    n_state = S_DN_L;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_chk_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_chk_vld <= n_chk_vld;
        end
        r_idx     <= n_idx;
        r_cur     <= n_cur;
        r_lft     <= n_lft;
        r_rvld    <= n_rvld;
        r_scan    <= n_scan;
        r_chk_idx <= n_chk_idx;
        r_status  <= n_status;
        r_okey    <= n_okey;
        r_oval    <= n_oval;
    end

    `HPQ_ASSERT(a_count_cap, r_count <= DEPTH_CAP, "heap count exceeds built depth")
    `HPQ_ASSERT(a_write_live, !w_we || (w_widx < r_count), "heap write beyond held entries")
    `HPQ_ASSERT_NEXT(a_count_step, 1'b1, (r_count - $past(r_count) + 7'd1) <= 7'd2, "count jump")

endmodule
